// ===== hdl/por_pkg.sv =====
// Shared constants and types for the pattern overwrite/replace block.
`default_nettype none

package por_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int CHAR_BITS_DEF   = 16;

    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 4;
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [LEN_REG_W-1:0] t_len_reg;

    localparam t_cfg_idx CFG_TARGET_LEN   = 3'd0;
    localparam t_cfg_idx CFG_TARGET_LO    = 3'd1;
    localparam t_cfg_idx CFG_TARGET_HI    = 3'd2;
    localparam t_cfg_idx CFG_REPLACE_LEN  = 3'd3;
    localparam t_cfg_idx CFG_REPLACE_LO   = 3'd4;
    localparam t_cfg_idx CFG_REPLACE_HI   = 3'd5;

    localparam t_len_reg TARGET_LEN_RST  = 4'd1;
    localparam t_len_reg REPLACE_LEN_RST = 4'd1;

endpackage

`default_nettype wire

// ===== hdl/por_in_if.sv =====
// Input character channel: valid/ready with one character and its last mark.
`default_nettype none

interface por_in_if #(
    parameter int CHAR_BITS = por_pkg::CHAR_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] content_char;
    logic                 is_last;

    modport source (output valid, content_char, is_last, input ready);
    modport sink   (input valid, content_char, is_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/por_out_if.sv =====
// Output character channel: valid/ready with one result character and its last mark.
`default_nettype none

interface por_out_if #(
    parameter int CHAR_BITS = por_pkg::CHAR_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] out_char;
    logic                 out_last;

    modport source (output valid, out_char, out_last, input ready);
    modport sink   (input valid, out_char, out_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/por_core.sv =====
// Lookahead window, parallel target compare and greedy overwrite scan for one beat.
`default_nettype none

module por_core #(
    parameter int MAX_PATTERN = por_pkg::MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = por_pkg::CHAR_BITS_DEF,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [CHAR_BITS-1:0] i_char,
    input  logic                 i_last,
    input  logic [LW-1:0]        i_tl,
    input  logic [LW-1:0]        i_rl,
    input  logic [CHAR_BITS-1:0] i_target [MAX_PATTERN],
    input  logic [CHAR_BITS-1:0] i_repl   [MAX_PATTERN],
    output logic [LW-1:0]        o_cnt,
    output logic [CHAR_BITS-1:0] o_chars  [MAX_PATTERN],
    output logic                 o_last
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SW = LW + 1;

    logic [CHAR_BITS-1:0] r_win [MAX_PATTERN];
    logic [LW-1:0]        r_wcnt;
    logic [LW-1:0]        r_idx;
    logic                 r_act;

    logic [CHAR_BITS-1:0] w         [MAX_PATTERN];
    logic [CHAR_BITS-1:0] res       [MAX_PATTERN];
    logic [CHAR_BITS-1:0] win_shift [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;
    logic [LW-1:0]        win_n;
    logic [LW-1:0]        ecnt;
    logic [LW-1:0]        scan_off;
    logic                 scan_cov;
    logic                 act_eff;
    logic [LW-1:0]        n_idx;

    // window with the new character appended at the fill position
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w[j] = (r_wcnt == LW'(j)) ? i_char : r_win[j];
        end
    end

    assign win_n   = r_wcnt + LW'(1);
    assign act_eff = r_act && (r_idx < i_rl);
    assign n_idx   = r_idx + LW'(1);

    // full-length target compare at every start position
    always_comb begin
        logic ok;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            ok = ((SW'(p) + SW'(i_tl)) <= SW'(win_n));
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (LW'(i) < i_tl) begin
                    if (p + i < MAX_PATTERN) begin
                        if (w[p + i] != i_target[i]) ok = 1'b0;
                    end else begin
                        ok = 1'b0;
                    end
                end
            end
            hit[p] = ok && (i_rl != '0);
        end
    end

    // greedy left-to-right scan: a hit covers rl positions, tail waits unless last
    always_comb begin
        logic          cov;
        logic          stop;
        logic [LW-1:0] off;
        cov  = 1'b0;
        stop = 1'b0;
        off  = '0;
        ecnt = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            res[j] = w[j];
            if ((LW'(j) < win_n) && !stop) begin
                if (cov) begin
                    res[j] = i_repl[off[IW-1:0]];
                    off    = off + LW'(1);
                    if (off == i_rl) cov = 1'b0;
                end else if (hit[j]) begin
                    res[j] = i_repl[0];
                    off    = LW'(1);
                    cov    = (i_rl > LW'(1));
                end else if (!(((SW'(j) + SW'(i_tl)) <= SW'(win_n)) || i_last)) begin
                    stop = 1'b1;
                end
                if (!stop) ecnt = LW'(j + 1);
            end
        end
        scan_cov = cov;
        scan_off = off;
    end

    // drop the emitted front of the window
    always_comb begin
        logic [SW-1:0] sh;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            sh = SW'(i) + SW'(ecnt);
            win_shift[i] = (sh < SW'(MAX_PATTERN)) ? w[sh[IW-1:0]] : w[i];
        end
    end

    always_comb begin
        o_cnt  = act_eff ? LW'(1) : ecnt;
        o_last = i_last;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            o_chars[j] = res[j];
        end
        if (act_eff) o_chars[0] = i_repl[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
            r_idx  <= '0;
            r_act  <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_wcnt <= '0;
                r_idx  <= '0;
                r_act  <= 1'b0;
            end else if (act_eff) begin
                if (n_idx >= i_rl) begin
                    r_act <= 1'b0;
                    r_idx <= '0;
                end else begin
                    r_idx <= n_idx;
                end
            end else begin
                r_wcnt <= win_n - ecnt;
                r_act  <= scan_cov;
                if (scan_cov) r_idx <= scan_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && !act_eff) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= win_shift[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/por_fifo.sv =====
// Output queue that takes a burst of up to MAX_PATTERN beats per cycle and drains one.
`default_nettype none

module por_fifo #(
    parameter int MAX_PATTERN = por_pkg::MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = por_pkg::CHAR_BITS_DEF,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [LW-1:0]        i_cnt,
    input  logic [CHAR_BITS-1:0] i_chars [MAX_PATTERN],
    input  logic                 i_last,
    output logic                 o_room,
    por_out_if.source            o_out
);

    localparam int DEPTH = 2 ** $clog2(2 * MAX_PATTERN);
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = PW + 1;
    localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CHAR_BITS-1:0] r_chr [DEPTH];
    logic                 r_lst [DEPTH];
    logic [PW-1:0]        r_wr;
    logic [PW-1:0]        r_rd;
    logic [CW-1:0]        r_cnt;

    logic [PW-1:0] woff [DEPTH];
    logic [LW-1:0] pcnt;
    logic          pop;

    assign pcnt = i_push ? i_cnt : '0;
    assign pop  = o_out.valid && o_out.ready;

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_char = r_chr[r_rd];
    assign o_out.out_last = r_lst[r_rd];
    // room for a full burst without counting this cycle's pop
    assign o_room         = (r_cnt <= CW'(DEPTH - MAX_PATTERN));

    always_comb begin
        for (int e = 0; e < DEPTH; e++) begin
            woff[e] = PW'(e) - r_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < DEPTH; e++) begin
            if (woff[e] < PW'(pcnt)) begin
                r_chr[e] <= i_chars[woff[e][IW-1:0]];
                r_lst[e] <= i_last && (woff[e] == (PW'(pcnt) - PW'(1)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PW'(pcnt);
            r_rd  <= r_rd + PW'(pop);
            r_cnt <= r_cnt + CW'(pcnt) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pattern_overwrite_replace.sv =====
// Top level: configuration registers, input register, scan core and output queue.
// Path: a character passes the input register, the scan core and the output queue; a character that may
//   start a match waits for up to target_len-1 further input beats before it is decided.
// Throughput: one input beat per cycle while the queue has room, set by the combinational compare
//   and scan; match bursts go into a queue of 2*MAX_PATTERN entries (rounded up to a power of two).
// Reset: synchronous, active low; clears window fill, overwrite state, queue, input valid and patterns; lengths to 1.
`default_nettype none

module pattern_overwrite_replace #(
    parameter int MAX_PATTERN = por_pkg::MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = por_pkg::CHAR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    por_in_if.sink                          i_in,
    por_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  por_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [por_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int LW      = $clog2(MAX_PATTERN + 1);
    localparam int SATW    = (LW > por_pkg::LEN_REG_W) ? LW : por_pkg::LEN_REG_W;
    localparam int PER_REG = por_pkg::CFG_DATA_W / CHAR_BITS;

    por_pkg::t_len_reg              r_tlen;
    por_pkg::t_len_reg              r_rlen;
    logic [por_pkg::CFG_DATA_W-1:0] r_tlo;
    logic [por_pkg::CFG_DATA_W-1:0] r_thi;
    logic [por_pkg::CFG_DATA_W-1:0] r_rlo;
    logic [por_pkg::CFG_DATA_W-1:0] r_rhi;

    logic                 r_in_vld;
    logic [CHAR_BITS-1:0] r_in_char;
    logic                 r_in_last;

    logic [LW-1:0]        tl;
    logic [LW-1:0]        rl;
    logic [CHAR_BITS-1:0] tgt  [MAX_PATTERN];
    logic [CHAR_BITS-1:0] repl [MAX_PATTERN];
    logic                 step_fire;
    logic                 fifo_room;
    logic [LW-1:0]        res_cnt;
    logic [CHAR_BITS-1:0] res_chars [MAX_PATTERN];
    logic                 res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen <= por_pkg::TARGET_LEN_RST;
            r_rlen <= por_pkg::REPLACE_LEN_RST;
            r_tlo  <= '0;
            r_thi  <= '0;
            r_rlo  <= '0;
            r_rhi  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                por_pkg::CFG_TARGET_LEN: begin
                    r_tlen <= i_cfg_data[por_pkg::LEN_REG_W-1:0];
                end
                por_pkg::CFG_TARGET_LO:   r_tlo <= i_cfg_data;
                por_pkg::CFG_TARGET_HI:   r_thi <= i_cfg_data;
                por_pkg::CFG_REPLACE_LEN: begin
                    r_rlen <= i_cfg_data[por_pkg::LEN_REG_W-1:0];
                end
                por_pkg::CFG_REPLACE_LO:  r_rlo <= i_cfg_data;
                por_pkg::CFG_REPLACE_HI:  r_rhi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lengths saturate at the window size
    assign tl = (SATW'(r_tlen) > SATW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(r_tlen);
    assign rl = (SATW'(r_rlen) > SATW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(r_rlen);

    // character slots past the two registers read as zero
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_slot
        if (i < PER_REG) begin : g_lo
            assign tgt[i]  = r_tlo[(i % PER_REG) * CHAR_BITS +: CHAR_BITS];
            assign repl[i] = r_rlo[(i % PER_REG) * CHAR_BITS +: CHAR_BITS];
        end else if (i < 2 * PER_REG) begin : g_hi
            assign tgt[i]  = r_thi[(i % PER_REG) * CHAR_BITS +: CHAR_BITS];
            assign repl[i] = r_rhi[(i % PER_REG) * CHAR_BITS +: CHAR_BITS];
        end else begin : g_zero
            assign tgt[i]  = '0;
            assign repl[i] = '0;
        end
    end

    assign step_fire  = r_in_vld && fifo_room;
    assign i_in.ready = !r_in_vld || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.content_char;
            r_in_last <= i_in.is_last;
        end
    end

    por_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .CHAR_BITS   (CHAR_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (step_fire),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .i_tl     (tl),
        .i_rl     (rl),
        .i_target (tgt),
        .i_repl   (repl),
        .o_cnt    (res_cnt),
        .o_chars  (res_chars),
        .o_last   (res_last)
    );

    por_fifo #(
        .MAX_PATTERN (MAX_PATTERN),
        .CHAR_BITS   (CHAR_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step_fire),
        .i_cnt   (res_cnt),
        .i_chars (res_chars),
        .i_last  (res_last),
        .o_room  (fifo_room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
